[src/sraw_pkg.sv]
package sraw_pkg;

  // Sequence space and window size
  localparam int SEQ_BITS = 6;
  localparam int WINDOW   = 32;

  // Field widths of the item ports
  localparam int REQ_FW  = 3;
  localparam int KIND_FW = 2;
  localparam int SEQ_FW  = SEQ_BITS;
  localparam int LEN_FW  = 12;
  localparam int ACT_FW  = 4;
  localparam int SLOT_FW = $clog2(WINDOW);
  localparam int CNT_FW  = $clog2(WINDOW + 1);

  // Request codes
  localparam logic [REQ_FW-1:0] REQ_UPPER    = 3'd0;
  localparam logic [REQ_FW-1:0] REQ_LINK     = 3'd1;
  localparam logic [REQ_FW-1:0] REQ_FRAME    = 3'd2;
  localparam logic [REQ_FW-1:0] REQ_DTIMEOUT = 3'd3;
  localparam logic [REQ_FW-1:0] REQ_ATIMEOUT = 3'd4;

  // Received frame kinds
  localparam logic [KIND_FW-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_FW-1:0] KIND_ACK    = 2'd1;
  localparam logic [KIND_FW-1:0] KIND_NAK    = 2'd2;
  localparam logic [KIND_FW-1:0] KIND_SEPACK = 2'd3;

  // Action codes
  localparam logic [ACT_FW-1:0] ACT_STORE   = 4'd0;
  localparam logic [ACT_FW-1:0] ACT_SEND    = 4'd1;
  localparam logic [ACT_FW-1:0] ACT_ACK     = 4'd2;
  localparam logic [ACT_FW-1:0] ACT_NAK     = 4'd3;
  localparam logic [ACT_FW-1:0] ACT_SEPACK  = 4'd4;
  localparam logic [ACT_FW-1:0] ACT_DELIVER = 4'd5;
  localparam logic [ACT_FW-1:0] ACT_RELEASE = 4'd6;
  localparam logic [ACT_FW-1:0] ACT_STOPTMR = 4'd7;
  localparam logic [ACT_FW-1:0] ACT_ACKTMR  = 4'd8;
  localparam logic [ACT_FW-1:0] ACT_STATUS  = 4'd9;

  // Shortest good frame, header plus CRC
  localparam logic [LEN_FW-1:0] LEN_MIN = 12'd5;

  typedef struct packed {
    logic [REQ_FW-1:0]  req_type;
    logic [KIND_FW-1:0] hdr_kind;
    logic [SEQ_FW-1:0]  frame_seq;
    logic [SEQ_FW-1:0]  hdr_ack;
    logic [LEN_FW-1:0]  frame_length;
    logic               crc_ok;
    logic [SEQ_FW-1:0]  timeout_seq;
  } in_item_t;

  typedef struct packed {
    logic [ACT_FW-1:0]  action;
    logic [SEQ_FW-1:0]  seq_value;
    logic [SEQ_FW-1:0]  ack_value;
    logic [SLOT_FW-1:0] slot;
    logic [CNT_FW-1:0]  release_count;
    logic               net_enable;
    logic               last;
  } out_item_t;

  // Controller to datapath: one bit per step of an item
  typedef struct packed {
    logic accept;
    logic decide;
    logic store;
    logic sepack;
    logic walk;
    logic acktmr;
    logic tail;
    logic status;
  } dp_cmd_t;

  // Datapath to controller: plan of the current item
  typedef struct packed {
    logic store_go;
    logic sepack_go;
    logic walk_go;
    logic tail_go;
    logic walk_more;
  } dp_sts_t;

endpackage

[src/sraw_ctrl.sv]
module sraw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sraw_pkg::dp_sts_t sts,
  output logic              busy,
  output sraw_pkg::dp_cmd_t cmd
);
  import sraw_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECIDE = 8'b0000_0010,
    ST_STORE  = 8'b0000_0100,
    ST_SEPACK = 8'b0000_1000,
    ST_WALK   = 8'b0001_0000,
    ST_ACKTMR = 8'b0010_0000,
    ST_TAIL   = 8'b0100_0000,
    ST_STATUS = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   after_store;

  // Pick the step that follows the delivery walk or a stored item
  assign after_store = sts.tail_go;

  // Sequence the result items of one input item
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (sts.store_go) state_nxt = ST_STORE;
        else if (sts.tail_go)      state_nxt = ST_TAIL;
        else                       state_nxt = ST_STATUS;
      end
      ST_STORE: begin
        priority if (sts.sepack_go) state_nxt = ST_SEPACK;
        else if (sts.walk_go)       state_nxt = ST_WALK;
        else if (after_store)       state_nxt = ST_TAIL;
        else                        state_nxt = ST_STATUS;
      end
      ST_SEPACK, ST_ACKTMR: begin
        state_nxt = after_store ? ST_TAIL : ST_STATUS;
      end
      ST_WALK: begin
        state_nxt = sts.walk_more ? ST_WALK : ST_ACKTMR;
      end
      ST_TAIL: begin
        state_nxt = ST_STATUS;
      end
      ST_STATUS: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive commands from the state
  assign busy       = (state_r != ST_IDLE);
  assign cmd.accept = start && (state_r == ST_IDLE);
  assign cmd.decide = (state_r == ST_DECIDE);
  assign cmd.store  = (state_r == ST_STORE);
  assign cmd.sepack = (state_r == ST_SEPACK);
  assign cmd.walk   = (state_r == ST_WALK);
  assign cmd.acktmr = (state_r == ST_ACKTMR);
  assign cmd.tail   = (state_r == ST_TAIL);
  assign cmd.status = (state_r == ST_STATUS);

`ifndef SYNTH
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == ST_DECIDE)
    else $error("accepted item did not enter decide");

  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STATUS |=> state_r == ST_IDLE && !busy)
    else $error("status item did not end the item");

  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> $past(state_r == ST_STATUS))
    else $error("busy dropped before status item");
`endif

endmodule

[src/sraw_dp.sv]
module sraw_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sraw_pkg::in_item_t in_data,
  input  sraw_pkg::dp_cmd_t  cmd,
  output sraw_pkg::dp_sts_t  sts,
  output logic               out_valid,
  output sraw_pkg::out_item_t out_data
);
  import sraw_pkg::*;

  localparam int SeqN  = 2 ** SEQ_BITS;
  localparam int SlotW = $clog2(WINDOW);
  localparam int OutW  = $clog2(WINDOW + 1);
  localparam int CntW  = SEQ_BITS + 1;
  localparam int CmpW  = (OutW > CntW) ? OutW : CntW;
  localparam logic [SEQ_BITS-1:0] LimitRst = SEQ_BITS'(WINDOW % SeqN);
  localparam logic [OutW-1:0]     WinFull  = OutW'(WINDOW);

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef slot_t               slot_lut_t [SeqN];

  // Slot of every sequence number, worked out at elaboration
  function automatic slot_lut_t build_slot_lut();
    slot_lut_t lut;
    for (int i = 0; i < SeqN; i++) begin
      lut[i] = SlotW'(i % WINDOW);
    end
    return lut;
  endfunction

  localparam slot_lut_t SLOT_LUT = build_slot_lut();

  function automatic logic in_win(seq_t b, seq_t t, seq_t e);
    return (t >= b && t < e) || (b > e && t >= b) || (b > e && t < e);
  endfunction

  // Latched input item
  logic [REQ_FW-1:0]  req_r;
  logic [KIND_FW-1:0] kind_r;
  seq_t               fseq_r, fack_r, tseq_r;
  logic [LEN_FW-1:0]  flen_r;
  logic               crc_r;

  // Window state
  seq_t              send_base_r, send_base_nxt;
  seq_t              send_next_r, send_next_nxt;
  logic [OutW-1:0]   outstanding_r, outstanding_nxt;
  seq_t              recv_expect_r;
  seq_t              recv_limit_r;
  logic [WINDOW-1:0] arrived_r;
  logic              nak_pending_r, nak_pending_nxt;
  logic              link_free_r, link_free_nxt;

  // Plan of the current item
  logic              net_en_r;
  logic              sepack_go_r, walk_go_r, tail_go_r;
  logic [ACT_FW-1:0] tail_act_r, tail_act_c;
  seq_t              tail_seq_r, tail_seq_c;
  seq_t              tail_ack_r, tail_ack_c;
  slot_t             tail_slot_r, tail_slot_c;
  logic [CntW-1:0]   tail_cnt_r, tail_cnt_c;
  logic              tail_go_c;

  // Decide-time terms
  logic            good, recv_in, arr_hit, store_c, sepack_c, walk_c, rel_in;
  seq_t            target, exp_next;
  slot_t           fs_slot, exp_slot, ns_slot, rd_slot;
  logic [CntW-1:0] rel_cnt;
  logic            walk_more;

  assign fs_slot  = SLOT_LUT[fseq_r];
  assign exp_slot = SLOT_LUT[recv_expect_r];
  assign exp_next = recv_expect_r + seq_t'(1);
  assign ns_slot  = SLOT_LUT[exp_next];

  // One read port on the arrival map
  assign rd_slot   = cmd.decide ? fs_slot : ns_slot;
  assign arr_hit   = arrived_r[rd_slot];
  assign walk_more = arr_hit && (ns_slot != exp_slot);

  assign good     = (flen_r >= LEN_MIN) && crc_r;
  assign recv_in  = in_win(recv_expect_r, fseq_r, recv_limit_r);
  assign store_c  = (req_r == REQ_FRAME) && good && (kind_r == KIND_DATA) && recv_in && !arr_hit;
  assign sepack_c = store_c && (fseq_r != recv_expect_r);
  assign walk_c   = store_c && (fseq_r == recv_expect_r);
  assign target   = fack_r - seq_t'(1);
  assign rel_in   = in_win(send_base_r, target, send_next_r);
  assign rel_cnt  = CntW'(seq_t'(target - send_base_r)) + CntW'(1);

  // Work out the send window and flag updates and the closing action of the item
  always_comb begin
    send_base_nxt   = send_base_r;
    send_next_nxt   = send_next_r;
    outstanding_nxt = outstanding_r;
    nak_pending_nxt = nak_pending_r;
    link_free_nxt   = link_free_r;
    tail_go_c       = 1'b0;
    tail_act_c      = ACT_STATUS;
    tail_seq_c      = '0;
    tail_ack_c      = '0;
    tail_slot_c     = '0;
    tail_cnt_c      = '0;
    unique case (req_r)
      REQ_UPPER: begin
        if (outstanding_r < WinFull) begin
          tail_go_c       = 1'b1;
          tail_act_c      = ACT_SEND;
          tail_seq_c      = send_next_r;
          tail_ack_c      = recv_expect_r;
          tail_slot_c     = SLOT_LUT[send_next_r];
          link_free_nxt   = 1'b0;
          send_next_nxt   = send_next_r + seq_t'(1);
          outstanding_nxt = outstanding_r + OutW'(1);
        end
      end
      REQ_LINK: begin
        link_free_nxt = 1'b1;
      end
      REQ_FRAME: begin
        if (!good) begin
          if (flen_r > LEN_MIN && !nak_pending_r) begin
            tail_go_c       = 1'b1;
            tail_act_c      = ACT_NAK;
            tail_ack_c      = recv_expect_r;
            nak_pending_nxt = 1'b1;
            link_free_nxt   = 1'b0;
          end
        end else begin
          if (sepack_c) link_free_nxt = 1'b0;
          unique case (kind_r)
            KIND_DATA, KIND_ACK: begin
              if (rel_in) begin
                tail_go_c     = 1'b1;
                tail_act_c    = ACT_RELEASE;
                tail_seq_c    = send_base_r;
                tail_cnt_c    = rel_cnt;
                send_base_nxt = fack_r;
                if (CmpW'(outstanding_r) > CmpW'(rel_cnt)) begin
                  outstanding_nxt = OutW'(CmpW'(outstanding_r) - CmpW'(rel_cnt));
                end else begin
                  outstanding_nxt = '0;
                end
              end
            end
            KIND_NAK: begin
              if (in_win(send_base_r, fack_r, send_next_r)) begin
                tail_go_c     = 1'b1;
                tail_act_c    = ACT_SEND;
                tail_seq_c    = fack_r;
                tail_ack_c    = recv_expect_r;
                tail_slot_c   = SLOT_LUT[fack_r];
                link_free_nxt = 1'b0;
              end
            end
            KIND_SEPACK: begin
              tail_go_c  = 1'b1;
              tail_act_c = ACT_STOPTMR;
              tail_seq_c = fack_r;
            end
            default: begin
              tail_go_c = 1'b0;
            end
          endcase
        end
      end
      REQ_DTIMEOUT: begin
        if (in_win(send_base_r, tseq_r, send_next_r)) begin
          tail_go_c     = 1'b1;
          tail_act_c    = ACT_SEND;
          tail_seq_c    = tseq_r;
          tail_ack_c    = recv_expect_r;
          tail_slot_c   = SLOT_LUT[tseq_r];
          link_free_nxt = 1'b0;
        end
      end
      REQ_ATIMEOUT: begin
        tail_go_c     = 1'b1;
        tail_act_c    = ACT_ACK;
        tail_ack_c    = recv_expect_r;
        link_free_nxt = 1'b0;
      end
      default: begin
        tail_go_c = 1'b0;
      end
    endcase
  end

  // Hold the input item and the plan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= in_data.req_type;
      kind_r <= in_data.hdr_kind;
      fseq_r <= SEQ_BITS'(in_data.frame_seq);
      fack_r <= SEQ_BITS'(in_data.hdr_ack);
      flen_r <= in_data.frame_length;
      crc_r  <= in_data.crc_ok;
      tseq_r <= SEQ_BITS'(in_data.timeout_seq);
    end
    if (cmd.decide) begin
      tail_act_r  <= tail_act_c;
      tail_seq_r  <= tail_seq_c;
      tail_ack_r  <= tail_ack_c;
      tail_slot_r <= tail_slot_c;
      tail_cnt_r  <= tail_cnt_c;
      net_en_r    <= (outstanding_nxt < WinFull) && link_free_nxt;
    end
  end

  // Advance window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_base_r   <= '0;
      send_next_r   <= '0;
      outstanding_r <= '0;
      recv_expect_r <= '0;
      recv_limit_r  <= LimitRst;
      arrived_r     <= '0;
      nak_pending_r <= 1'b0;
      link_free_r   <= 1'b0;
      sepack_go_r   <= 1'b0;
      walk_go_r     <= 1'b0;
      tail_go_r     <= 1'b0;
    end else begin
      if (cmd.decide) begin
        send_base_r   <= send_base_nxt;
        send_next_r   <= send_next_nxt;
        outstanding_r <= outstanding_nxt;
        nak_pending_r <= nak_pending_nxt;
        link_free_r   <= link_free_nxt;
        sepack_go_r   <= sepack_c;
        walk_go_r     <= walk_c;
        tail_go_r     <= tail_go_c;
      end
      if (cmd.store) begin
        arrived_r[fs_slot] <= 1'b1;
      end
      if (cmd.walk) begin
        arrived_r[exp_slot] <= 1'b0;
        recv_expect_r       <= exp_next;
        recv_limit_r        <= recv_limit_r + seq_t'(1);
        nak_pending_r       <= 1'b0;
      end
    end
  end

  // Report the plan
  assign sts.store_go  = store_c;
  assign sts.sepack_go = sepack_go_r;
  assign sts.walk_go   = walk_go_r;
  assign sts.tail_go   = cmd.decide ? tail_go_c : tail_go_r;
  assign sts.walk_more = walk_more;

  // Select the result item for this step
  assign out_valid = cmd.store || cmd.sepack || cmd.walk || cmd.acktmr || cmd.tail || cmd.status;

  always_comb begin
    out_data            = '0;
    out_data.net_enable = net_en_r;
    out_data.action     = ACT_STATUS;
    priority if (cmd.store) begin
      out_data.action    = ACT_STORE;
      out_data.seq_value = SEQ_FW'(fseq_r);
      out_data.slot      = SLOT_FW'(fs_slot);
    end else if (cmd.sepack) begin
      out_data.action    = ACT_SEPACK;
      out_data.seq_value = SEQ_FW'(fseq_r);
      out_data.ack_value = SEQ_FW'(fseq_r);
    end else if (cmd.walk) begin
      out_data.action    = ACT_DELIVER;
      out_data.seq_value = SEQ_FW'(recv_expect_r);
      out_data.slot      = SLOT_FW'(exp_slot);
    end else if (cmd.acktmr) begin
      out_data.action = ACT_ACKTMR;
    end else if (cmd.tail) begin
      out_data.action        = tail_act_r;
      out_data.seq_value     = SEQ_FW'(tail_seq_r);
      out_data.ack_value     = SEQ_FW'(tail_ack_r);
      out_data.slot          = SLOT_FW'(tail_slot_r);
      out_data.release_count = CNT_FW'(tail_cnt_r);
    end else begin
      out_data.action = ACT_STATUS;
      out_data.last   = cmd.status;
    end
  end

`ifndef SYNTH
  a_limit_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    recv_limit_r == seq_t'(recv_expect_r + LimitRst))
    else $error("receive window edges out of step");

  a_outstanding_max: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= WinFull)
    else $error("outstanding count above window");

  a_release_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tail && tail_act_r == ACT_RELEASE |->
      send_base_r == seq_t'(tail_seq_r + seq_t'(tail_cnt_r)))
    else $error("send base does not match released count");
`endif

endmodule

[src/selective_repeat_arq_window.sv]
// Channel   Ports                           Handshake
// input     start, busy, in_data            taken when start is high and busy is low
// result    out_valid, out_data             one cycle per item, strobe out_valid
//
// An item has 1 to WINDOW + 4 results; while busy it first decides the plan, then
// gives one result item per cycle.
// The in-order delivery walk over the arrival map, one slot per cycle, sets the
// longest items; the next item can start the cycle after the status result.
// rst_n is synchronous and active low; it clears the window state and the arrival map.
// The receiver cannot stall: each result is presented for exactly one cycle.
module selective_repeat_arq_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sraw_pkg::in_item_t  in_data,
  output logic                out_valid,
  output sraw_pkg::out_item_t out_data
);
  import sraw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sraw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  sraw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sraw_pkg::*;

  localparam int WIN          = 32;
  localparam int SEQ_TOP      = 63;
  localparam int LEN_TOP      = 4095;
  localparam int IDLE_PCT     = 36;
  localparam int ITEM_GOAL    = 300;
  localparam int DRAIN_CYCLES = 60;

  // Request codes the block does not define
  localparam logic [REQ_FW-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [REQ_FW-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [REQ_FW-1:0] REQ_SPARE_C = 3'd7;

  // Tracks both window edges and queues the actions each event must produce
  class arq_window_check;
    logic [SEQ_FW-1:0] tx_base, tx_next, rx_expect, rx_limit;
    int unsigned       tx_inflight;
    bit                rx_held [WIN];
    bit                nak_sent, link_idle;
    out_item_t         step_actions[$];
    out_item_t         expected_actions[$];
    int                errors;

    function new();
      tx_base     = '0;
      tx_next     = '0;
      tx_inflight = 0;
      rx_expect   = '0;
      rx_limit    = SEQ_FW'(WIN);
      foreach (rx_held[i]) rx_held[i] = 1'b0;
      nak_sent    = 1'b0;
      link_idle   = 1'b0;
      errors      = 0;
    endfunction

    // Circular membership test, b inclusive, e exclusive
    function bit in_win(logic [SEQ_FW-1:0] b, logic [SEQ_FW-1:0] t, logic [SEQ_FW-1:0] e);
      return (t >= b && t < e) || (b > e && t >= b) || (b > e && t < e);
    endfunction

    function void add_action(logic [ACT_FW-1:0] act, logic [SEQ_FW-1:0] seq,
                             logic [SEQ_FW-1:0] ack, logic [SLOT_FW-1:0] slt,
                             logic [CNT_FW-1:0] cnt);
      out_item_t r;
      r = '0;
      r.action        = act;
      r.seq_value     = seq;
      r.ack_value     = ack;
      r.slot          = slt;
      r.release_count = cnt;
      step_actions.push_back(r);
    endfunction

    function void queue_send(logic [SEQ_FW-1:0] seq);
      add_action(ACT_SEND, seq, rx_expect, seq[SLOT_FW-1:0], '0);
      link_idle = 1'b0;
    endfunction

    // Predict the actions of one accepted event and queue them
    function void note_event(in_item_t it);
      logic [SEQ_FW-1:0]  first, target;
      logic [SLOT_FW-1:0] s;
      int unsigned        cnt;
      bit                 delivered, ne;
      out_item_t          r;
      step_actions.delete();
      case (it.req_type)
        REQ_UPPER: begin
          if (tx_inflight < WIN) begin
            queue_send(tx_next);
            tx_next++;
            tx_inflight++;
          end
        end
        REQ_LINK: link_idle = 1'b1;
        REQ_FRAME: begin
          if (it.frame_length < LEN_MIN || !it.crc_ok) begin
            // drop the frame; ask for a resend once per gap
            if (it.frame_length > LEN_MIN && !nak_sent) begin
              add_action(ACT_NAK, '0, rx_expect, '0, '0);
              nak_sent  = 1'b1;
              link_idle = 1'b0;
            end
          end else begin
            if (it.hdr_kind == KIND_DATA && in_win(rx_expect, it.frame_seq, rx_limit)) begin
              s = it.frame_seq[SLOT_FW-1:0];
              if (!rx_held[s]) begin
                delivered  = 1'b0;
                rx_held[s] = 1'b1;
                add_action(ACT_STORE, it.frame_seq, '0, s, '0);
                if (it.frame_seq != rx_expect) begin
                  add_action(ACT_SEPACK, it.frame_seq, it.frame_seq, '0, '0);
                  link_idle = 1'b0;
                end
                // walk the arrival map, delivering in order
                while (rx_held[rx_expect[SLOT_FW-1:0]]) begin
                  add_action(ACT_DELIVER, rx_expect, '0, rx_expect[SLOT_FW-1:0], '0);
                  rx_held[rx_expect[SLOT_FW-1:0]] = 1'b0;
                  rx_expect++;
                  rx_limit++;
                  nak_sent  = 1'b0;
                  delivered = 1'b1;
                end
                if (delivered) add_action(ACT_ACKTMR, '0, '0, '0, '0);
              end
            end
            if (it.hdr_kind == KIND_DATA || it.hdr_kind == KIND_ACK) begin
              // advance the send base up to the piggybacked ack
              first  = tx_base;
              cnt    = 0;
              target = it.hdr_ack - 1'b1;
              while (cnt <= SEQ_TOP && in_win(tx_base, target, tx_next)) begin
                tx_base++;
                cnt++;
                if (tx_inflight > 0) tx_inflight--;
              end
              if (cnt > 0) add_action(ACT_RELEASE, first, '0, '0, CNT_FW'(cnt));
            end else if (it.hdr_kind == KIND_NAK) begin
              if (in_win(tx_base, it.hdr_ack, tx_next)) queue_send(it.hdr_ack);
            end else begin
              add_action(ACT_STOPTMR, it.hdr_ack, '0, '0, '0);
            end
          end
        end
        REQ_DTIMEOUT: begin
          if (in_win(tx_base, it.timeout_seq, tx_next)) queue_send(it.timeout_seq);
        end
        REQ_ATIMEOUT: begin
          add_action(ACT_ACK, '0, rx_expect, '0, '0);
          link_idle = 1'b0;
        end
        default: ;
      endcase
      add_action(ACT_STATUS, '0, '0, '0, '0);
      ne = (tx_inflight < WIN) && link_idle;
      foreach (step_actions[i]) begin
        r            = step_actions[i];
        r.net_enable = ne;
        r.last       = (i == step_actions.size() - 1);
        expected_actions.push_back(r);
      end
    endfunction

    // Compare one result against the oldest expected action
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_actions.size() == 0) begin
        $display("%0t: unexpected result act=%0d seq=%0d ack=%0d slot=%0d cnt=%0d ne=%0d last=%0d",
                 $time, got.action, got.seq_value, got.ack_value, got.slot,
                 got.release_count, got.net_enable, got.last);
        errors++;
        return;
      end
      want = expected_actions.pop_front();
      if (got.action !== want.action || got.seq_value !== want.seq_value ||
          got.ack_value !== want.ack_value || got.slot !== want.slot ||
          got.release_count !== want.release_count ||
          got.net_enable !== want.net_enable || got.last !== want.last) begin
        $display("%0t: mismatch expected act=%0d seq=%0d ack=%0d slot=%0d cnt=%0d ne=%0d last=%0d",
                 $time, want.action, want.seq_value, want.ack_value, want.slot,
                 want.release_count, want.net_enable, want.last);
        $display("%0t:          actual   act=%0d seq=%0d ack=%0d slot=%0d cnt=%0d ne=%0d last=%0d",
                 $time, got.action, got.seq_value, got.ack_value, got.slot,
                 got.release_count, got.net_enable, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  arq_window_check board;
  int              items_sent = 0;
  bit              calm = 1'b0;

  selective_repeat_arq_window dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  function automatic in_item_t make_item(logic [REQ_FW-1:0] req, logic [KIND_FW-1:0] kind,
                                         int seq, int ack, int len, bit crc, int tseq);
    in_item_t it;
    it.req_type     = req;
    it.hdr_kind     = kind;
    it.frame_seq    = SEQ_FW'(seq);
    it.hdr_ack      = SEQ_FW'(ack);
    it.frame_length = LEN_FW'(len);
    it.crc_ok       = crc;
    it.timeout_seq  = SEQ_FW'(tseq);
    return it;
  endfunction

  // Hold the item until taken, then idle at random
  task automatic offer_item(in_item_t it);
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_event(it);
    if (it.req_type <= REQ_ATIMEOUT) items_sent++;
    calm = (items_sent >= 120 && items_sent < 180);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 45)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    offer_item(make_item(REQ_FRAME, KIND_DATA, 0, 0, 5, 1, 0));      // in-order minimal frame
    offer_item(make_item(REQ_UPPER, KIND_DATA, 0, 0, 0, 0, 0));      // send, link busy
    offer_item(make_item(REQ_LINK, KIND_DATA, 0, 0, 0, 0, 0));
    offer_item(make_item(REQ_UPPER, KIND_DATA, 0, 0, 0, 0, 0));
    offer_item(make_item(REQ_ATIMEOUT, KIND_DATA, 0, 0, 0, 0, 0));
    offer_item(make_item(REQ_DTIMEOUT, KIND_DATA, 0, 0, 0, 0, 0));   // live timeout
    offer_item(make_item(REQ_DTIMEOUT, KIND_DATA, 0, 0, 0, 0, SEQ_TOP)); // stale timeout
    offer_item(make_item(REQ_FRAME, KIND_DATA, 0, 0, 4, 1, 0));      // short frame
    offer_item(make_item(REQ_FRAME, KIND_DATA, 0, 0, 5, 0, 0));      // bad CRC, no nak
    offer_item(make_item(REQ_FRAME, KIND_DATA, 0, 0, 6, 0, 0));      // bad CRC, nak
    offer_item(make_item(REQ_FRAME, KIND_DATA, 0, 0, LEN_TOP, 0, 0)); // nak already out
    offer_item(make_item(REQ_FRAME, KIND_DATA, 2, 0, LEN_TOP, 1, 0)); // out of order
    offer_item(make_item(REQ_FRAME, KIND_NAK, 0, 0, 9, 1, 0));
    offer_item(make_item(REQ_FRAME, KIND_SEPACK, 0, 1, 9, 1, 0));
    offer_item(make_item(REQ_FRAME, KIND_ACK, 0, 2, 9, 1, 0));
    offer_item(make_item(REQ_FRAME, KIND_DATA, 1, 0, 9, 1, 0));      // fills the gap
    offer_item(make_item(REQ_FRAME, KIND_DATA, SEQ_TOP, SEQ_TOP, 9, 1, 0)); // outside window
    offer_item(make_item(REQ_FRAME, KIND_DATA, 34, 0, 9, 1, 0));     // top edge of window
    offer_item(make_item(REQ_FRAME, KIND_DATA, 34, 0, 9, 1, 0));     // duplicate
    offer_item(make_item(REQ_FRAME, KIND_DATA, 35, 0, 9, 1, 0));     // just past window
    offer_item(make_item(REQ_SPARE_A, KIND_DATA, 0, 0, 0, 0, 0));
    offer_item(make_item(REQ_SPARE_B, KIND_DATA, 0, 0, 0, 0, 0));
    offer_item(make_item(REQ_SPARE_C, KIND_SEPACK, SEQ_TOP, SEQ_TOP, LEN_TOP, 1, SEQ_TOP));
    offer_item(make_item(REQ_FRAME, KIND_SEPACK, SEQ_TOP, SEQ_TOP, LEN_TOP, 1, SEQ_TOP));
  endtask

  // Build one random event, mostly aimed at the live windows
  function automatic in_item_t random_event();
    in_item_t    it;
    logic [63:0] raw;
    int          c;
    int          k;
    raw = {$urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    c   = $urandom_range(99);
    if (c < 20) begin
      it.req_type = REQ_UPPER;
    end else if (c < 28) begin
      it.req_type = REQ_LINK;
    end else if (c < 66) begin
      it.req_type     = REQ_FRAME;
      it.crc_ok       = 1'b1;
      it.frame_length = ($urandom_range(3) == 0) ? LEN_MIN : LEN_FW'($urandom_range(5, LEN_TOP));
      k = $urandom_range(99);
      it.hdr_kind = (k < 50) ? KIND_DATA : (k < 75) ? KIND_ACK : (k < 87) ? KIND_NAK
                                                                      : KIND_SEPACK;
      if ($urandom_range(9) < 7)
        it.frame_seq = board.rx_expect +
                       SEQ_FW'(($urandom_range(2) == 0) ? 0 : $urandom_range(1, WIN - 1));
      if ($urandom_range(3) != 0)
        it.hdr_ack = board.tx_base + SEQ_FW'($urandom_range(0, board.tx_inflight));
    end else if (c < 76) begin
      it.req_type = REQ_FRAME;
      if ($urandom_range(1) == 0) it.frame_length = LEN_FW'($urandom_range(0, 4));
      else begin
        it.crc_ok = 1'b0;
        if ($urandom_range(1) == 0) it.frame_length = LEN_FW'($urandom_range(0, 8));
      end
    end else if (c < 86) begin
      it.req_type = REQ_DTIMEOUT;
      if ($urandom_range(9) < 7)
        it.timeout_seq = board.tx_base + SEQ_FW'($urandom_range(0, board.tx_inflight));
    end else if (c < 93) begin
      it.req_type = REQ_ATIMEOUT;
    end
    return it;
  endfunction

  task automatic run_random();
    int                pick;
    int                n;
    logic [SEQ_FW-1:0] base;
    in_item_t          it;
    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // fill a receive gap backward so the last frame releases a long walk
        n    = ($urandom_range(2) == 0) ? WIN - 1 : $urandom_range(1, WIN - 1);
        base = board.rx_expect;
        for (int k = n; k >= 0; k--) begin
          it = make_item(REQ_FRAME, KIND_DATA, base + k, board.tx_base,
                         $urandom_range(5, LEN_TOP), 1, 0);
          offer_item(it);
        end
      end else if (pick < 9) begin
        // flood the send window, then push past it
        while (board.tx_inflight < WIN)
          offer_item(make_item(REQ_UPPER, KIND_DATA, 0, 0, 0, 0, 0));
        repeat ($urandom_range(1, 2)) offer_item(make_item(REQ_UPPER, KIND_DATA, 0, 0, 0, 0, 0));
      end else begin
        offer_item(random_event());
      end
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    start <= 1'b0;
    while (board.expected_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.expected_actions.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
